// ----- hw/rtl/dfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dfsp_pkg
// Shared types and constants of the dark/flat/sky pixel calibration core.
// ----------------------------------------------------------------------------
package dfsp_pkg;

  localparam int unsigned PIXEL_BITS_DEF = 16;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FLAT_W   = 20;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned BIAS_W   = 17;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned OUT_W    = 32;

  // Q.12 dark-corrected sample, quotient of the flat division, signed Q.12 after sky
  localparam int unsigned DARK_W = 28;
  localparam int unsigned NUM_W  = DARK_W + 16;
  localparam int unsigned SKY_D_W = NUM_W + 2;

  // Divider: quotient bits resolved per pipeline stage
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;

  // Output modes
  localparam logic [MODE_W-1:0] MODE_WIDE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLAMP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DARK_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_BIAS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_ENABLE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SKY_ENABLE  = 3'd7;

  // Channel codes
  localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
  localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_sample;
    logic [SAMPLE_W-1:0] dark_sample;
    logic [FLAT_W-1:0]   flat_sample;
    logic [SAMPLE_W-1:0] sky_sample;
    logic [CHAN_W-1:0]   channel;
  } dfsp_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] pixel_out;
    logic                    clipped;
  } dfsp_result_t;

  // Fields that ride alongside the divider
  typedef struct packed {
    logic [SAMPLE_W-1:0] sky_sample;
    logic [CHAN_W-1:0]   channel;
    logic                zero_flat;
  } dfsp_side_t;

endpackage

// ----- hw/rtl/dfsp_divider.sv -----
// ----------------------------------------------------------------------------
// dfsp_divider
// Pipelined restoring divider: DIV_BITS quotient bits per stage, one new
// transaction per cycle, side data carried alongside each transaction.
// ----------------------------------------------------------------------------
module dfsp_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [dfsp_pkg::NUM_W-1:0]    dividend,
  input  logic [dfsp_pkg::FLAT_W-1:0]   divisor,
  input  dfsp_pkg::dfsp_side_t          in_side,
  output logic                          out_valid,
  output logic [dfsp_pkg::NUM_W-1:0]    quotient,
  output dfsp_pkg::dfsp_side_t          out_side
);
  import dfsp_pkg::*;

  logic               valid_q [DIV_STAGES];
  logic [FLAT_W-1:0]  rem_q   [DIV_STAGES];
  logic [NUM_W-1:0]   num_q   [DIV_STAGES];
  logic [FLAT_W-1:0]  den_q   [DIV_STAGES];
  dfsp_side_t         side_q  [DIV_STAGES];

  genvar s;
  generate
    for (s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic              valid_in;
      logic [FLAT_W-1:0] rem_in;
      logic [NUM_W-1:0]  num_in;
      logic [FLAT_W-1:0] den_in;
      dfsp_side_t        side_in;
      logic [FLAT_W-1:0] rem_next;
      logic [NUM_W-1:0]  num_next;

      if (s == 0) begin : g_first
        assign valid_in = in_valid;
        assign rem_in   = '0;
        assign num_in   = dividend;
        assign den_in   = divisor;
        assign side_in  = in_side;
      end else begin : g_rest
        assign valid_in = valid_q[s-1];
        assign rem_in   = rem_q[s-1];
        assign num_in   = num_q[s-1];
        assign den_in   = den_q[s-1];
        assign side_in  = side_q[s-1];
      end

      // Shift in one dividend bit, subtract the divisor when it fits; the
      // quotient bits fill the dividend register from the bottom.
      always_comb begin
        logic [FLAT_W:0]   trial;
        logic [FLAT_W-1:0] r;
        logic [NUM_W-1:0]  n;
        r = rem_in;
        n = num_in;
        for (int k = 0; k < DIV_BITS; k++) begin
          trial = {r, n[NUM_W-1]};
          if (trial >= {1'b0, den_in}) begin
            r = FLAT_W'(trial - {1'b0, den_in});
            n = {n[NUM_W-2:0], 1'b1};
          end else begin
            r = trial[FLAT_W-1:0];
            n = {n[NUM_W-2:0], 1'b0};
          end
        end
        rem_next = r;
        num_next = n;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_in;
        end
        rem_q[s]  <= rem_next;
        num_q[s]  <= num_next;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  endgenerate

  // Every stage resolves DIV_BITS bits, so the quotient fills the whole register
  assign out_valid = valid_q[DIV_STAGES-1];
  assign quotient  = num_q[DIV_STAGES-1];
  assign out_side  = side_q[DIV_STAGES-1];

endmodule

// ----- hw/rtl/dark_flat_sky_pixel_calibration_core.sv -----
// ----------------------------------------------------------------------------
// dark_flat_sky_pixel_calibration_core
// Per-sample dark subtraction, flat division, sky subtraction, white balance,
// soft bias and output range handling in a fixed-latency pipeline.
// ----------------------------------------------------------------------------
//  channel   signals                      transaction
//  --------  ---------------------------  -----------------------------------
//  item      start, busy, item            taken when start && !busy
//  result    done, result                 one cycle wide, always taken
//  config    cfg_we, cfg_index, cfg_data  written when cfg_we is high
//
//  One transaction per cycle while busy is low; done rises once the item has
//  passed the entry stage, 11-stage divider, sky stage, two multiply stages,
//  bias add and output register. Synchronous reset empties the pipeline and
//  loads register defaults; busy is high for the reset cycles only. The result
//  side has no back-pressure.
// ----------------------------------------------------------------------------
module dark_flat_sky_pixel_calibration_core #(
  parameter int unsigned PIXEL_BITS = dfsp_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  dfsp_pkg::dfsp_item_t              item,
  output logic                              done,
  output dfsp_pkg::dfsp_result_t            result,
  input  logic                              cfg_we,
  input  logic [dfsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dfsp_pkg::*;

  localparam int unsigned LATENCY = DIV_STAGES + 6;
  localparam int unsigned RES_W   = 40;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned LO_W    = 23;
  localparam int unsigned HI_W    = SKY_D_W - LO_W;
  localparam int unsigned BYTE_SHIFT = PIXEL_BITS + 16;

  localparam logic signed [RES_W-1:0] TOP_WIDE = {{(RES_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [RES_W-1:0] LO_WIDE  = {{(RES_W-31){1'b1}}, 31'd0};
  localparam logic signed [RES_W-1:0] TOP_PIX  =
    {{(RES_W-PIXEL_BITS){1'b0}}, {PIXEL_BITS{1'b1}}};
  localparam logic signed [RES_W-1:0] TOP_BYTE = RES_W'(255);

  // Configuration registers
  logic [GAIN_W-1:0] dark_gain;
  logic [GAIN_W-1:0] gain_red;
  logic [GAIN_W-1:0] gain_green;
  logic [GAIN_W-1:0] gain_blue;
  logic [BIAS_W-1:0] soft_bias;
  logic [MODE_W-1:0] output_mode;
  logic              flat_enable;
  logic              sky_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_gain   <= GAIN_UNITY;
      gain_red    <= GAIN_UNITY;
      gain_green  <= GAIN_UNITY;
      gain_blue   <= GAIN_UNITY;
      soft_bias   <= '0;
      output_mode <= MODE_WIDE;
      flat_enable <= 1'b0;
      sky_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DARK_GAIN:   dark_gain   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_RED:    gain_red    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_GREEN:  gain_green  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_BLUE:   gain_blue   <= cfg_data[GAIN_W-1:0];
        REG_SOFT_BIAS:   soft_bias   <= cfg_data[BIAS_W-1:0];
        REG_OUTPUT_MODE: output_mode <= cfg_data[MODE_W-1:0];
        REG_FLAT_ENABLE: flat_enable <= cfg_data[0];
        REG_SKY_ENABLE:  sky_enable  <= cfg_data[0];
      endcase
    end
  end

  // Mode three behaves as wide
  logic              mode_clamp;
  logic              mode_byte;
  logic [5:0]        shift_amt;
  logic signed [RES_W-1:0] top;
  logic signed [RES_W-1:0] bottom;

  always_comb begin
    mode_clamp = (output_mode == MODE_CLAMP);
    mode_byte  = (output_mode == MODE_BYTE);
    shift_amt  = mode_byte ? 6'(BYTE_SHIFT) : 6'd24;
    if (mode_clamp) begin
      top    = TOP_PIX;
      bottom = '0;
    end else if (mode_byte) begin
      top    = TOP_BYTE;
      bottom = '0;
    end else begin
      top    = TOP_WIDE;
      bottom = LO_WIDE;
    end
  end

  // Bias Q.24 + round half; user holds config stable while items flow, unenforced
  logic signed [ACC_W-1:0] bias_half;

  always_ff @(posedge clk) begin
    bias_half <= (ACC_W'($signed(soft_bias)) <<< 24) +
                 (ACC_W'(1) << (shift_amt - 6'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Stage 1: scaled dark subtraction, clamp at zero
  logic                  s1_valid;
  logic [NUM_W-1:0]      s1_dividend;
  logic [FLAT_W-1:0]     s1_divisor;
  dfsp_side_t            s1_side;
  logic [31:0]           dark_prod;
  logic [DARK_W-1:0]     raw_q12;
  logic [DARK_W-1:0]     dark_diff;

  always_comb begin
    dark_prod = item.dark_sample * dark_gain;
    raw_q12   = {item.raw_sample, 12'd0};
    dark_diff = (dark_prod > {4'd0, raw_q12}) ? '0 : DARK_W'({4'd0, raw_q12} - dark_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_dividend <= {dark_diff, 16'd0};
    // With the flat off, dividing by 1.0 passes the sample unchanged
    s1_divisor  <= flat_enable ? item.flat_sample : FLAT_W'(65536);
    s1_side.sky_sample <= item.sky_sample;
    s1_side.channel    <= item.channel;
    s1_side.zero_flat  <= flat_enable && (item.flat_sample == '0);
  end

  logic              dv_valid;
  logic [NUM_W-1:0]  dv_quot;
  dfsp_side_t        dv_side;

  dfsp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .dividend  (s1_dividend),
    .divisor   (s1_divisor),
    .in_side   (s1_side),
    .out_valid (dv_valid),
    .quotient  (dv_quot),
    .out_side  (dv_side)
  );

  // Stage A: sky subtraction and gain select
  logic                      a_valid;
  logic signed [SKY_D_W-1:0] a_d;
  logic [GAIN_W-1:0]         a_gain;
  logic                      a_zero;
  logic [GAIN_W-1:0]         gain_sel;
  logic signed [SKY_D_W-1:0] sky_term;

  always_comb begin
    unique case (dv_side.channel)
      CH_RED:   gain_sel = gain_red;
      CH_GREEN: gain_sel = gain_green;
      CH_BLUE:  gain_sel = gain_blue;
      default:  gain_sel = GAIN_UNITY;
    endcase
    sky_term = sky_enable ? $signed(SKY_D_W'({dv_side.sky_sample, 12'd0})) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= dv_valid;
    end
    a_d    <= $signed(SKY_D_W'(dv_quot)) - sky_term;
    a_gain <= gain_sel;
    a_zero <= dv_side.zero_flat;
  end

  // Stage M1: split product, low half unsigned, high half signed
  logic                        m1_valid;
  logic [LO_W+GAIN_W-1:0]      m1_lo;
  logic signed [HI_W+GAIN_W:0] m1_hi;
  logic                        m1_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= a_valid;
    end
    m1_lo   <= a_d[LO_W-1:0] * a_gain;
    m1_hi   <= $signed(a_d[SKY_D_W-1:LO_W]) * $signed({1'b0, a_gain});
    m1_zero <= a_zero;
  end

  // Stage M2: combine partial products
  logic                    m2_valid;
  logic signed [ACC_W-1:0] m2_acc;
  logic                    m2_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
    m2_acc  <= (ACC_W'(m1_hi) <<< LO_W) + $signed(ACC_W'(m1_lo));
    m2_zero <= m1_zero;
  end

  // Stage M3: add bias and rounding half
  logic                    m3_valid;
  logic signed [ACC_W-1:0] m3_t;
  logic                    m3_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= m2_valid;
    end
    m3_t    <= m2_acc + bias_half;
    m3_zero <= m2_zero;
  end

  // Stage R: floor shift, zero-flat override, clamp, drive the result
  logic signed [ACC_W-1:0] shifted;
  logic signed [RES_W-1:0] res;
  dfsp_result_t            result_next;

  always_comb begin
    shifted = mode_byte ? (m3_t >>> BYTE_SHIFT) : (m3_t >>> 24);
    res     = shifted[RES_W-1:0];
    priority if (m3_zero) begin
      result_next.pixel_out = top[OUT_W-1:0];
      result_next.clipped   = 1'b1;
    end else if (res > top) begin
      result_next.pixel_out = top[OUT_W-1:0];
      result_next.clipped   = 1'b1;
    end else if (res < bottom) begin
      result_next.pixel_out = bottom[OUT_W-1:0];
      result_next.clipped   = 1'b1;
    end else begin
      result_next.pixel_out = res[OUT_W-1:0];
      result_next.clipped   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m3_valid;
    end
    result <= result_next;
  end

  // Every result traces back to an item taken a fixed number of cycles earlier
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching item");

  assert property (@(posedge clk) disable iff (rst)
    done && mode_byte |-> (result.pixel_out >= 0) && (result.pixel_out <= 255))
    else $error("byte mode result out of range");

  assert property (@(posedge clk) disable iff (rst)
    done && mode_clamp && result.clipped |->
      (result.pixel_out == 0) || (result.pixel_out == TOP_PIX[OUT_W-1:0]))
    else $error("clamped result not at a range limit");

  assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("busy raised outside reset");

endmodule

// ----- tb/sv/dfsp_calibration_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsp_calibration_checker
// Watches the item, result and register channels of the calibration core,
// keeps its own copy of the registers, computes each calibrated sample and
// compares it in order with the results that the core delivers.
// ----------------------------------------------------------------------------
module dfsp_calibration_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  dfsp_pkg::dfsp_item_t            item,
  input  logic                            done,
  input  dfsp_pkg::dfsp_result_t          result,
  input  logic                            cfg_we,
  input  logic [dfsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfsp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              outstanding
);
  import dfsp_pkg::*;

  localparam int unsigned PIXEL_BITS = PIXEL_BITS_DEF;

  logic [GAIN_W-1:0]        dark_gain_q;
  logic [GAIN_W-1:0]        gain_red_q;
  logic [GAIN_W-1:0]        gain_green_q;
  logic [GAIN_W-1:0]        gain_blue_q;
  logic signed [BIAS_W-1:0] soft_bias_q;
  logic [MODE_W-1:0]        output_mode_q;
  logic                     flat_enable_q;
  logic                     sky_enable_q;

  dfsp_result_t             pending_pixels[$];
  dfsp_result_t             oldest;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic dfsp_result_t calibrate_sample(input dfsp_item_t it);
    longint       raw, dark, flat, sky, dgain, gain, bias;
    longint       top, lo, d, v, res;
    int unsigned  shift;
    logic [MODE_W-1:0] mode;
    dfsp_result_t r;
    raw   = it.raw_sample;
    dark  = it.dark_sample;
    flat  = it.flat_sample;
    sky   = it.sky_sample;
    dgain = dark_gain_q;
    bias  = soft_bias_q;
    // the spare mode code falls back to wide output
    mode = (output_mode_q == MODE_CLAMP || output_mode_q == MODE_BYTE) ?
           output_mode_q : MODE_WIDE;
    case (mode)
      MODE_CLAMP: begin
        top   = (longint'(1) <<< PIXEL_BITS) - 1;
        lo    = 0;
        shift = 24;
      end
      MODE_BYTE: begin
        top   = 255;
        lo    = 0;
        shift = 24 + PIXEL_BITS - 8;
      end
      default: begin
        top   = 2147483647;
        lo    = -(longint'(1) <<< 31);
        shift = 24;
      end
    endcase
    r.clipped = 1'b0;
    // a zero flat pins the output at the top of the range
    if (flat_enable_q && flat == 0) begin
      r.pixel_out = top[OUT_W-1:0];
      r.clipped   = 1'b1;
      return r;
    end
    d = raw * 4096 - dark * dgain;
    if (d < 0) d = 0;
    if (flat_enable_q) d = (d * 65536) / flat;
    if (sky_enable_q) d = d - sky * 4096;
    case (it.channel)
      CH_RED:   gain = gain_red_q;
      CH_GREEN: gain = gain_green_q;
      CH_BLUE:  gain = gain_blue_q;
      default:  gain = GAIN_UNITY;
    endcase
    v   = d * gain + bias * 64'sd16777216;
    // round half up, then floor through the arithmetic shift
    res = (v + (longint'(1) <<< (shift - 1))) >>> shift;
    if (res > top) begin
      res       = top;
      r.clipped = 1'b1;
    end else if (res < lo) begin
      res       = lo;
      r.clipped = 1'b1;
    end
    r.pixel_out = res[OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dark_gain_q   = GAIN_UNITY;
      gain_red_q    = GAIN_UNITY;
      gain_green_q  = GAIN_UNITY;
      gain_blue_q   = GAIN_UNITY;
      soft_bias_q   = '0;
      output_mode_q = MODE_WIDE;
      flat_enable_q = 1'b0;
      sky_enable_q  = 1'b0;
      pending_pixels.delete();
    end else begin
      if (done) begin
        if (pending_pixels.size() == 0) begin
          $error("result with no pending transaction: pixel_out %0d clipped %0b",
                 result.pixel_out, result.clipped);
          fail_count++;
        end else begin
          oldest = pending_pixels.pop_front();
          if (result.pixel_out !== oldest.pixel_out) begin
            $error("pixel_out: expected %0d, actual %0d",
                   oldest.pixel_out, result.pixel_out);
            fail_count++;
          end
          if (result.clipped !== oldest.clipped) begin
            $error("clipped: expected %0b, actual %0b", oldest.clipped, result.clipped);
            fail_count++;
          end
        end
      end
      // predict with the registers as they stand before this edge's write
      if (start && !busy) pending_pixels.push_back(calibrate_sample(item));
      if (cfg_we) begin
        case (cfg_index)
          REG_DARK_GAIN:   dark_gain_q   = cfg_data[GAIN_W-1:0];
          REG_GAIN_RED:    gain_red_q    = cfg_data[GAIN_W-1:0];
          REG_GAIN_GREEN:  gain_green_q  = cfg_data[GAIN_W-1:0];
          REG_GAIN_BLUE:   gain_blue_q   = cfg_data[GAIN_W-1:0];
          REG_SOFT_BIAS:   soft_bias_q   = cfg_data[BIAS_W-1:0];
          REG_OUTPUT_MODE: output_mode_q = cfg_data[MODE_W-1:0];
          REG_FLAT_ENABLE: flat_enable_q = cfg_data[0];
          REG_SKY_ENABLE:  sky_enable_q  = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding = pending_pixels.size();
  end

endmodule

// ----- tb/sv/dark_flat_sky_pixel_calibration_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dark_flat_sky_pixel_calibration_core_test
// Drives directed and random samples through the calibration core under
// changing register settings and sender gaps; the checker beside the core
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module dark_flat_sky_pixel_calibration_core_test;
  import dfsp_pkg::*;

  localparam int STALL_LIMIT        = 2000;
  localparam int SETTLE_CYCLES      = 32;
  localparam int SETTINGS_PER_PHASE = 6;
  localparam int ITEMS_PER_SETTING  = 64;

  // codes with no name in the package
  localparam logic [CHAN_W-1:0] CH_SPARE   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  dfsp_item_t            item;
  logic                  done;
  dfsp_result_t          result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int outstanding;
  int idle_pct;
  int stall_cycles;

  dark_flat_sky_pixel_calibration_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dfsp_calibration_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // count cycles in which no transaction of any kind happens
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stall_cycles = 0;
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic dfsp_item_t sample_of(input logic [SAMPLE_W-1:0] raw,
                                           input logic [SAMPLE_W-1:0] dark,
                                           input logic [FLAT_W-1:0]   flat,
                                           input logic [SAMPLE_W-1:0] sky,
                                           input logic [CHAN_W-1:0]   ch);
    dfsp_item_t it;
    it.raw_sample  = raw;
    it.dark_sample = dark;
    it.flat_sample = flat;
    it.sky_sample  = sky;
    it.channel     = ch;
    return it;
  endfunction

  task automatic send_pixel(input dfsp_item_t it);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    // busy at the falling edge is what the next rising edge samples
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] dark_gain,
                           input logic [CFG_DATA_W-1:0] gain_red,
                           input logic [CFG_DATA_W-1:0] gain_green,
                           input logic [CFG_DATA_W-1:0] gain_blue,
                           input logic [CFG_DATA_W-1:0] soft_bias,
                           input logic [CFG_DATA_W-1:0] output_mode,
                           input logic [CFG_DATA_W-1:0] flat_enable,
                           input logic [CFG_DATA_W-1:0] sky_enable);
    // hold off until the pipeline is empty
    drain_results();
    write_reg(REG_DARK_GAIN, dark_gain);
    write_reg(REG_GAIN_RED, gain_red);
    write_reg(REG_GAIN_GREEN, gain_green);
    write_reg(REG_GAIN_BLUE, gain_blue);
    write_reg(REG_SOFT_BIAS, soft_bias);
    write_reg(REG_OUTPUT_MODE, output_mode);
    write_reg(REG_FLAT_ENABLE, flat_enable);
    write_reg(REG_SKY_ENABLE, sky_enable);
    cfg_we <= 1'b0;
  endtask

  // set unused upper data bits now and then; the register keeps its low bits
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input int w);
    logic [CFG_DATA_W-1:0] mask;
    mask = ~((17'd1 << w) - 17'd1);
    if ($urandom_range(1)) return v | (CFG_DATA_W'($urandom) & mask);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    logic [GAIN_W-1:0] g;
    case ($urandom_range(7))
      0:       g = '0;
      1:       g = '1;
      2:       g = GAIN_UNITY;
      default: g = GAIN_W'($urandom);
    endcase
    return with_junk({1'b0, g}, GAIN_W);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_bias();
    case ($urandom_range(5))
      0:       return 17'h10000;
      1:       return 17'h0FFFF;
      2:       return '0;
      3:       return CFG_DATA_W'($urandom_range(255));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic dfsp_item_t random_pixel();
    logic [SAMPLE_W-1:0] raw, dark, sky;
    logic [FLAT_W-1:0]   flat;
    raw = SAMPLE_W'($urandom);
    case ($urandom_range(3))
      0: dark = SAMPLE_W'($urandom);
      1: dark = raw >> $urandom_range(1, 8);
      2: dark = '0;
      default: dark = SAMPLE_W'($urandom_range(255));
    endcase
    case ($urandom_range(9))
      0: flat = '0;
      1: flat = FLAT_W'($urandom_range(1, 255));
      2: flat = FLAT_W'($urandom);
      3: flat = '1;
      default: flat = FLAT_W'($urandom_range(32768, 131072));
    endcase
    case ($urandom_range(2))
      0: sky = SAMPLE_W'($urandom);
      1: sky = SAMPLE_W'($urandom_range(2047));
      default: sky = raw >> 2;
    endcase
    return sample_of(raw, dark, flat, sky, CHAN_W'($urandom_range(3)));
  endfunction

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 17;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults straight out of reset; third sample clamps the dark
    send_pixel(sample_of(16'h0000, 16'h0000, 20'h00000, 16'h0000, CH_RED));
    send_pixel(sample_of(16'hFFFF, 16'h0000, 20'hFFFFF, 16'hFFFF, CH_GREEN));
    send_pixel(sample_of(16'h0000, 16'hFFFF, 20'h00000, 16'h0000, CH_BLUE));
    send_pixel(sample_of(16'hFFFF, 16'hFFFF, 20'h00000, 16'h0000, CH_SPARE));
    send_pixel(sample_of(16'd1234, 16'd1000, 20'd65536, 16'd77, CH_SPARE));

    configure(17'd0, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'd0, CFG_DATA_W'(MODE_CLAMP),
              17'd1, 17'd1);
    send_pixel(sample_of(16'd1000, 16'd0, 20'h00000, 16'd0, CH_RED));
    send_pixel(sample_of(16'hFFFF, 16'd0, 20'h00001, 16'd0, CH_GREEN));
    send_pixel(sample_of(16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'd0, CH_BLUE));
    send_pixel(sample_of(16'h0000, 16'd0, 20'd65536, 16'hFFFF, CH_RED));
    send_pixel(sample_of(16'd1000, 16'd0, 20'd65536, 16'd10, CH_SPARE));

    configure(17'h0FFFF, {1'b0, GAIN_UNITY}, {1'b0, GAIN_UNITY}, {1'b0, GAIN_UNITY},
              17'h0FFFF, CFG_DATA_W'(MODE_BYTE), 17'd1, 17'd0);
    send_pixel(sample_of(16'd500, 16'd0, 20'h00000, 16'd0, CH_GREEN));
    send_pixel(sample_of(16'hFFFF, 16'd0, 20'd65536, 16'd0, CH_RED));
    send_pixel(sample_of(16'h0000, 16'hFFFF, 20'd65536, 16'd0, CH_BLUE));
    send_pixel(sample_of(16'd100, 16'd0, 20'd65536, 16'hFFFF, CH_GREEN));

    configure({1'b0, GAIN_UNITY}, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF,
              17'h10000, CFG_DATA_W'(MODE_SPARE), 17'd1, 17'd1);
    send_pixel(sample_of(16'd9, 16'd3, 20'h00000, 16'd5, CH_BLUE));
    send_pixel(sample_of(16'hFFFF, 16'd0, 20'h00001, 16'd0, CH_RED));
    send_pixel(sample_of(16'h0000, 16'd0, 20'd65536, 16'hFFFF, CH_BLUE));
    send_pixel(sample_of(16'd5000, 16'd4000, 20'd70000, 16'd100, CH_RED));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 70 : 0;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        configure(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_bias(),
                  with_junk(CFG_DATA_W'($urandom_range(3)), MODE_W),
                  with_junk(CFG_DATA_W'($urandom_range(1)), 1),
                  with_junk(CFG_DATA_W'($urandom_range(1)), 1));
        for (int n = 0; n < ITEMS_PER_SETTING; n++) send_pixel(random_pixel());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dfsp_pkg.sv
hw/rtl/dfsp_divider.sv
hw/rtl/dark_flat_sky_pixel_calibration_core.sv
tb/sv/dfsp_calibration_checker.sv
tb/sv/dark_flat_sky_pixel_calibration_core_test.sv
